// ===== design/psl_pkg.sv =====
// ----------------------------------------------------------------------------
// psl_pkg: shared types and constants for the portamento slew limiter
// Sample, time, rate and divisor widths, and the sample-rate reset value.
// ----------------------------------------------------------------------------
package psl_pkg;

	localparam int SAMPLE_BITS = 24;
	localparam int TIME_W      = 24;
	localparam int RATE_W      = 18;
	localparam int PROD_W      = TIME_W + RATE_W;
	localparam int FRAC_BITS   = 16;
	localparam int DIV_CNT_W   = (SAMPLE_BITS > 1) ? $clog2(SAMPLE_BITS) : 1;

	localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(48000);
	localparam logic [PROD_W-1:0] ONE_SAMPLE = PROD_W'(1) << FRAC_BITS;

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;
	typedef logic [SAMPLE_BITS-1:0]        mag_t;
	typedef logic [TIME_W-1:0]             time_t;
	typedef logic [RATE_W-1:0]             rate_t;
	typedef logic [PROD_W-1:0]             prod_t;

endpackage

// ===== design/psl_if.sv =====
// ----------------------------------------------------------------------------
// psl_if: handshake channels of the portamento slew limiter
// Input sample channel, result channel and sample-rate write channel.
// ----------------------------------------------------------------------------
interface psl_in_if import psl_pkg::*; ();
	logic    valid;
	logic    ready;
	sample_t sample_in;
	time_t   rise_time;
	time_t   fall_time;

	modport source (output valid, sample_in, rise_time, fall_time, input ready);
	modport sink   (input valid, sample_in, rise_time, fall_time, output ready);
endinterface

interface psl_out_if import psl_pkg::*; ();
	logic    valid;
	logic    ready;
	sample_t sample_out;

	modport source (output valid, sample_out, input ready);
	modport sink   (input valid, sample_out, output ready);
endinterface

interface psl_cfg_if import psl_pkg::*; ();
	logic  valid;
	logic  ready;
	rate_t rate_hz;

	modport source (output valid, rate_hz, input ready);
	modport sink   (input valid, rate_hz, output ready);
endinterface

// ===== design/psl_div.sv =====
// ----------------------------------------------------------------------------
// psl_div: radix-2 restoring divider for the slide step
// Computes (mag << 16) / divisor, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module psl_div import psl_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	input  mag_t  mag,
	input  prod_t divisor,
	output logic  done,
	output mag_t  quot
);

	logic [SAMPLE_BITS+FRAC_BITS-1:0] num_w;
	logic [PROD_W-1:0]                rem_q;
	mag_t                             lo_q;
	logic [DIV_CNT_W-1:0]             cnt_q;
	logic                             busy_q;
	logic                             done_q;
	logic [PROD_W:0]                  trial_w;
	logic [PROD_W:0]                  diff_w;
	logic                             fits_w;

	assign num_w   = {mag, FRAC_BITS'(0)};
	// remainder stays below divisor, so the shifted trial fits one extra bit
	assign trial_w = {rem_q, lo_q[SAMPLE_BITS-1]};
	assign diff_w  = trial_w - {1'b0, divisor};
	assign fits_w  = (trial_w >= {1'b0, divisor});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(SAMPLE_BITS - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			// top 16 bits of the numerator are below any divisor that gets here
			rem_q <= {(PROD_W-FRAC_BITS)'(0), num_w[SAMPLE_BITS+FRAC_BITS-1:SAMPLE_BITS]};
			lo_q  <= num_w[SAMPLE_BITS-1:0];
		end else if (busy_q) begin
			rem_q <= fits_w ? diff_w[PROD_W-1:0] : trial_w[PROD_W-1:0];
			lo_q  <= {lo_q[SAMPLE_BITS-2:0], fits_w};
		end
	end

	assign done = done_q;
	assign quot = lo_q;

endmodule

// ===== design/portamento_slew_limiter.sv =====
// ----------------------------------------------------------------------------
// portamento_slew_limiter: linear slide toward the latest distinct sample
// Step per sample is (target - start) * 65536 / (time * rate_hz).
//
//   channel     dir   payload                              handshake
//   sample_ch   in    sample_in, rise_time, fall_time      valid/ready
//   result_ch   out   sample_out                           valid/ready
//   cfg         in    rate_hz                              valid/ready
//
// One word at a time: accept, setup/multiply, check, then the divider
// and a finish state; a jump to the target (time zero or under one
// sample) skips the divider and goes from check straight to finish.
// sample_ch is ready only while idle. A finished word sits in the output
// register; the finish cycle waits there only if the previous word is unread.
// Reset clears slide state and output valid; rate_hz resets to 48000.
// ----------------------------------------------------------------------------
module portamento_slew_limiter import psl_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	psl_in_if.sink    sample_ch,
	psl_out_if.source result_ch,
	psl_cfg_if.sink   cfg
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SETUP,
		ST_CHECK,
		ST_DIV,
		ST_FIN
	} state_t;

	state_t  state_q;
	rate_t   rate_q;
	sample_t start_q;
	sample_t target_q;
	sample_t prev_q;
	time_t   rise_q;
	time_t   fall_q;
	logic    rising_q;
	logic    nz_q;
	logic    jump_q;
	mag_t    mag_q;
	prod_t   d_q;
	logic    out_valid_q;
	sample_t out_q;

	logic                    accept_w;
	logic                    rising_w;
	time_t                   t_w;
	logic signed [SAMPLE_BITS:0] delta_w;
	logic [SAMPLE_BITS:0]    abs_w;
	logic                    div_start_w;
	logic                    div_done_w;
	mag_t                    quot_w;
	mag_t                    step_mag_w;
	logic signed [SAMPLE_BITS+1:0] step_w;
	logic signed [SAMPLE_BITS+1:0] y_w;
	logic signed [SAMPLE_BITS+1:0] tgt_w;
	logic                    clamp_w;
	sample_t                 y_fin_w;
	logic                    load_out_w;

	assign accept_w        = sample_ch.valid && (state_q == ST_IDLE);
	assign sample_ch.ready = (state_q == ST_IDLE);
	assign cfg.ready       = 1'b1;

	// setup: direction, time select, delta magnitude
	assign rising_w = (target_q > start_q);
	assign t_w      = rising_w ? rise_q : fall_q;
	assign delta_w  = {target_q[SAMPLE_BITS-1], target_q} - {start_q[SAMPLE_BITS-1], start_q};
	assign abs_w    = delta_w[SAMPLE_BITS] ? -delta_w : delta_w;

	assign div_start_w = (state_q == ST_CHECK) && (d_q >= ONE_SAMPLE);

	psl_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start_w),
		.mag     (mag_q),
		.divisor (d_q),
		.done    (div_done_w),
		.quot    (quot_w)
	);

	// finish: stalled step becomes one code, then add and clamp at target
	assign step_mag_w = (quot_w == '0 && nz_q) ? SAMPLE_BITS'(1) : quot_w;
	assign step_w     = rising_q ? $signed({2'b00, step_mag_w}) : -$signed({2'b00, step_mag_w});
	assign y_w        = {{2{prev_q[SAMPLE_BITS-1]}}, prev_q} + step_w;
	assign tgt_w      = {{2{target_q[SAMPLE_BITS-1]}}, target_q};
	assign clamp_w    = rising_q ? (y_w > tgt_w) : (y_w < tgt_w);
	assign y_fin_w    = (jump_q || clamp_w) ? target_q : y_w[SAMPLE_BITS-1:0];

	assign load_out_w = (state_q == ST_FIN) && (!out_valid_q || result_ch.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rate_q      <= RATE_RESET;
			start_q     <= '0;
			target_q    <= '0;
			prev_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg.valid) begin
				rate_q <= cfg.rate_hz;
			end
			if (load_out_w) begin
				out_valid_q <= 1'b1;
			end else if (result_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept_w) begin
						if (sample_ch.sample_in != target_q) begin
							start_q  <= prev_q;
							target_q <= sample_ch.sample_in;
						end
						state_q <= ST_SETUP;
					end
				end
				ST_SETUP: state_q <= ST_CHECK;
				ST_CHECK: state_q <= div_start_w ? ST_DIV : ST_FIN;
				ST_DIV: begin
					if (div_done_w) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (load_out_w) begin
						prev_q  <= y_fin_w;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept_w) begin
			rise_q <= sample_ch.rise_time;
			fall_q <= sample_ch.fall_time;
		end
		if (state_q == ST_SETUP) begin
			rising_q <= rising_w;
			d_q      <= PROD_W'(t_w) * PROD_W'(rate_q);
			mag_q    <= abs_w[SAMPLE_BITS-1:0];
			nz_q     <= (delta_w != '0);
		end
		if (state_q == ST_CHECK) begin
			jump_q <= !div_start_w;
		end
		if (load_out_w) begin
			out_q <= y_fin_w;
		end
	end

	assign result_ch.valid      = out_valid_q;
	assign result_ch.sample_out = out_q;

endmodule

// ===== dv/portamento_slew_limiter_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// portamento_slew_limiter_tb: self-checking bench for the slew limiter
// Feeds sample words, including directed corner cases and held random targets,
// at several sample rates. Both handshake sides idle in random bursts. Every
// result word is checked against an in-bench slide predictor.
// ----------------------------------------------------------------------------
module portamento_slew_limiter_tb;
	import psl_pkg::*;

	localparam int STALL_LIMIT = 2000;
	localparam int RANDOM_PER_PHASE = 310;
	localparam int NUM_PHASES = 6;

	// Tracks slide state and holds the expected output words in order.
	class slide_scoreboard;
		longint  slide_from;
		longint  slide_to;
		longint  last_out;
		rate_t   rate;
		sample_t expected_out[$];
		int      errors;

		function new();
			slide_from = 0;
			slide_to   = 0;
			last_out   = 0;
			rate       = RATE_RESET;
			errors     = 0;
		endfunction

		function void note_sample(sample_t s, time_t rise, time_t fall);
			longint x;
			longint d;
			longint delta;
			longint step;
			longint y;
			bit     up;
			time_t  t;
			x = s;
			if (x != slide_to) begin
				slide_from = last_out;
				slide_to   = x;
			end
			up = slide_to > slide_from;
			t  = up ? rise : fall;
			if (t == 0) begin
				y = x;
			end else begin
				d = longint'(t) * longint'(rate);
				if (d < 65536) begin
					y = slide_to;
				end else begin
					delta = slide_to - slide_from;
					step  = (delta * 65536) / d;
					// never let the slide stall short of the target
					if (step == 0 && delta != 0)
						step = (delta > 0) ? 1 : -1;
					y = last_out + step;
					if ((up && y > slide_to) || (!up && y < slide_to))
						y = slide_to;
				end
			end
			last_out = y;
			expected_out.push_back(sample_t'(y));
		endfunction

		function void check_sample_out(sample_t got);
			sample_t want;
			if (expected_out.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result word: sample_out=%0d", got);
			end else begin
				want = expected_out.pop_front();
				if (got !== want) begin
					errors++;
					if (errors <= 10)
						$display("sample_out mismatch: expected %0d, got %0d", want, got);
				end
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	psl_in_if  sample_ch();
	psl_out_if result_ch();
	psl_cfg_if cfg();

	slide_scoreboard sb;

	int gap_pct;
	int stall_pct;
	int stall_left = 0;
	int stalled_cycles = 0;

	portamento_slew_limiter i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.sample_ch (sample_ch),
		.result_ch (result_ch),
		.cfg       (cfg)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// result side back-pressure
	always @(negedge clk) begin
		if (stall_left != 0) begin
			stall_left--;
			result_ch.ready <= 1'b0;
		end else if ($urandom_range(99) < stall_pct) begin
			stall_left = $urandom_range(1, 11) - 1;
			result_ch.ready <= 1'b0;
		end else begin
			result_ch.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_ch.valid && result_ch.ready)
			sb.check_sample_out(result_ch.sample_out);
	end

	always @(posedge clk) begin
		if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready) ||
		    (cfg.valid && cfg.ready)) begin
			stalled_cycles = 0;
		end else begin
			stalled_cycles++;
			if (stalled_cycles >= STALL_LIMIT) begin
				$display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
				$display("portamento_slew_limiter_tb: done, errors");
				$finish;
			end
		end
	end

	// Starts and ends on a falling edge; valid stays up into the next word.
	task automatic send_word(sample_t s, time_t rise, time_t fall);
		if ($urandom_range(99) < gap_pct) begin
			sample_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(negedge clk);
		end
		sample_ch.valid     <= 1'b1;
		sample_ch.sample_in <= s;
		sample_ch.rise_time <= rise;
		sample_ch.fall_time <= fall;
		@(posedge clk);
		while (!sample_ch.ready) @(posedge clk);
		sb.note_sample(s, rise, fall);
		@(negedge clk);
	endtask

	task automatic drain_results();
		sample_ch.valid <= 1'b0;
		while (sb.expected_out.size() != 0) @(negedge clk);
	endtask

	task automatic write_rate(rate_t v);
		cfg.valid   <= 1'b1;
		cfg.rate_hz <= v;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		sb.rate = v;
		@(negedge clk);
		cfg.valid <= 1'b0;
	endtask

	function automatic time_t pick_time();
		case ($urandom_range(9))
			0, 1:    return '0;
			2, 3, 4: return time_t'($urandom_range(1, 64));
			5, 6:    return time_t'($urandom_range(65, 4096));
			7:       return time_t'($urandom_range(1, 3));
			default: return time_t'($urandom);
		endcase
	endfunction

	function automatic sample_t pick_sample(sample_t prev);
		int off;
		off = int'($urandom_range(0, 16)) - 8;
		case ($urandom_range(7))
			0, 1, 2, 3: return sample_t'($urandom);
			4, 5:       return sample_t'(prev + off);
			6:          return $urandom_range(1) ? sample_t'(24'h7FFFFF) : sample_t'(24'h800000);
			default:    return sample_t'(int'($urandom_range(0, 512)) - 256);
		endcase
	endfunction

	// Mostly held targets with random times, so slides can run on over many words;
	// the rest is single-word noise.
	task automatic run_random(int n);
		sample_t s = '0;
		time_t   rise = '0;
		time_t   fall = '0;
		int      hold = 0;
		for (int i = 0; i < n; i++) begin
			if (hold == 0) begin
				if ($urandom_range(99) < 85) begin
					s    = pick_sample(s);
					rise = pick_time();
					fall = pick_time();
					hold = $urandom_range(1, 40);
				end else begin
					s    = sample_t'($urandom);
					rise = time_t'($urandom);
					fall = time_t'($urandom);
					hold = 1;
				end
			end
			send_word(s, rise, fall);
			hold--;
		end
	endtask

	task automatic run_directed();
		send_word(24'sh7FFFFF, 24'h0, 24'h0);               // full scale, pass-through
		send_word(-24'sh800000, 24'h0, 24'h0);              // negative full scale
		send_word(24'sh7FFFFF, 24'h1, 24'h1);               // under one sample: jump
		repeat (4) send_word(24'sh0, 24'h10, 24'h10);       // long falling slide
		send_word(24'sh0, 24'h0, 24'h0);                    // fall time zero mid-slide
		repeat (2) send_word(24'sh5, 24'hFFFFFF, 24'h0);    // step truncates to zero
		send_word(-24'sh5, 24'h0, 24'hFFFFFF);              // same, falling
		repeat (2) send_word(24'sha, 24'h2, 24'h2);         // overshoot clamps at target
		send_word(24'sh00c8, 24'hFFFFFF, 24'h0);
		send_word(24'sh000b, 24'h0, 24'h5);                 // start equals target: fall time
		send_word(24'sh000b, 24'h0, 24'h0);
		send_word(-24'sh800000, 24'hFFFFFF, 24'h1);
		send_word(24'sh7FFFFF, 24'h800000, 24'h0);
		send_word(24'sh7FFFFF, 24'h7FFFFF, 24'h0);
		send_word(-24'sh1, 24'h000100, 24'h000100);
	endtask

	initial begin
		rate_t rates[NUM_PHASES];
		rates = '{RATE_RESET, rate_t'(0), rate_t'(1), rate_t'(18'h3FFFF),
		          rate_t'(192000), rate_t'($urandom_range(1, 192000))};
		clk                 = 1'b0;
		arst_n              = 1'b0;
		sample_ch.valid     = 1'b0;
		sample_ch.sample_in = '0;
		sample_ch.rise_time = '0;
		sample_ch.fall_time = '0;
		cfg.valid           = 1'b0;
		cfg.rate_hz         = RATE_RESET;
		gap_pct             = 25;
		stall_pct           = 15;
		sb = new();

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		run_directed();
		for (int p = 0; p < NUM_PHASES; p++) begin
			// the reset value of the rate covers the first phase
			if (p > 0) begin
				drain_results();
				write_rate(rates[p]);
			end
			if (p == NUM_PHASES - 1) begin
				gap_pct   = 0;
				stall_pct = 0;
			end else begin
				gap_pct   = $urandom_range(0, 2) * 20;
				stall_pct = $urandom_range(0, 2) * 15;
			end
			run_random(RANDOM_PER_PHASE);
		end
		drain_results();
		repeat (40) @(posedge clk);

		if (sb.errors == 0)
			$display("portamento_slew_limiter_tb: done, clean");
		else
			$display("portamento_slew_limiter_tb: done, errors");
		$finish;
	end

endmodule
